[hw/rtl/cbt_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the cubic Bezier tessellator core.
// Used by every module under hw/rtl; depends on nothing else.

package cbt_pkg;

   // Fixed-point format and coordinate width
   localparam int FRAC_BITS   = 16;
   localparam int COORD_W     = 32;

   // Segment count handling
   localparam int CNT_W          = 6;
   localparam int MAX_SEGMENTS   = 63;
   localparam int MIN_SEGMENTS   = 2;
   localparam int SEG_COUNT_RST  = 20;

   // Bernstein numerators and the cube of the segment count
   localparam int NUM_W       = 3 * CNT_W;
   localparam int SQ_W        = 2 * CNT_W;

   // Weight is an unsigned fraction in [0, 1], so one integer bit
   localparam int W_W         = FRAC_BITS + 1;
   localparam int DIV_STEPS   = FRAC_BITS + 1;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

   // Product and accumulator widths
   localparam int PROD_W      = COORD_W + FRAC_BITS + 2;
   localparam int ACC_W       = PROD_W - FRAC_BITS + 2;

   // Job queue between front and engine
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   // Control register port
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 6;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SEGMENT_COUNT  = 1'b0,
      CSR_STROKE_ENABLED = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] p0_x;
      logic signed [COORD_W-1:0] p0_y;
      logic signed [COORD_W-1:0] p0_z;
      logic signed [COORD_W-1:0] c1_x;
      logic signed [COORD_W-1:0] c1_y;
      logic signed [COORD_W-1:0] c1_z;
      logic signed [COORD_W-1:0] c2_x;
      logic signed [COORD_W-1:0] c2_y;
      logic signed [COORD_W-1:0] c2_z;
      logic signed [COORD_W-1:0] p3_x;
      logic signed [COORD_W-1:0] p3_y;
      logic signed [COORD_W-1:0] p3_z;
   } in_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] curve_x;
      logic signed [COORD_W-1:0] curve_y;
      logic signed [COORD_W-1:0] curve_z;
      logic                      last_point;
   } out_type;

   // One accepted curve with its segment count
   typedef struct packed {
      logic [CNT_W-1:0] n;
      in_type           pts;
   } job_type;

   // Write side of the job queue
   typedef struct packed {
      logic    push;
      job_type job;
   } push_type;

   typedef enum logic [2:0] {
      ENG_IDLE,
      ENG_CUBE,
      ENG_POW,
      ENG_NUM,
      ENG_DIV,
      ENG_MAC,
      ENG_PUSH
   } eng_state_type;

endpackage

[hw/rtl/cbt_front.sv]
`timescale 1ns / 1ps
// Front end: control registers, input handshake and item classification.
// Depends on cbt_pkg; feeds the job queue.

module cbt_front import cbt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  in_type                req_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  q_full,
   output push_type              q_wr
);

   logic [CNT_W-1:0] seg_count_ff;
   logic [CNT_W-1:0] seg_count_in;
   logic             stroke_ff;
   logic             stroke_in;
   logic [CNT_W-1:0] n_clamped;
   logic             keep;

   // Decode register writes
   always_comb begin
      seg_count_in = seg_count_ff;
      stroke_in    = stroke_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SEGMENT_COUNT:  seg_count_in = csr_wdata[CNT_W-1:0];
            CSR_STROKE_ENABLED: stroke_in    = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_count_ff <= CNT_W'(SEG_COUNT_RST);
         stroke_ff    <= 1'b1;
      end else begin
         seg_count_ff <= seg_count_in;
         stroke_ff    <= stroke_in;
      end
   end

   // Clamp the segment count and drop items that draw nothing
   always_comb begin
      n_clamped = (seg_count_ff > CNT_W'(MAX_SEGMENTS)) ? CNT_W'(MAX_SEGMENTS) : seg_count_ff;
      keep      = stroke_ff && (n_clamped >= CNT_W'(MIN_SEGMENTS));
   end

   // Accept whenever the queue has room; dropped items go nowhere
   assign req_ready    = !q_full;
   assign q_wr.push    = req_valid && req_ready && keep;
   assign q_wr.job.n   = n_clamped;
   assign q_wr.job.pts = req_data;

endmodule

[hw/rtl/cbt_fifo.sv]
`timescale 1ns / 1ps
// Two-entry job queue between the front end and the evaluation engine.
// Depends on cbt_pkg for the job type and queue sizing.

module cbt_fifo import cbt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  push_type wr,
   output logic     full,
   output logic     head_valid,
   output job_type  head,
   input  logic     pop
);

   job_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic [QPTR_W-1:0] wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_in;
   logic [QCNT_W-1:0] count_in;
   logic              do_push;
   logic              do_pop;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];
   assign do_push    = wr.push && !full;
   assign do_pop     = pop && head_valid;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the job payload
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr.job;
      end
   end

endmodule

[hw/rtl/cbt_div.sv]
`timescale 1ns / 1ps
// Restoring divider for one Bernstein weight: floor((num << FRAC_BITS) / den).
// One quotient bit per cycle; depends on cbt_pkg. Requires num <= den.

module cbt_div import cbt_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [NUM_W-1:0] den,
   output logic             done,
   output logic [W_W-1:0]   quot
);

   logic [NUM_W-1:0]     rem_ff;
   logic [NUM_W-1:0]     rem_in;
   logic                 nb_ff;
   logic                 nb_in;
   logic [W_W-1:0]       quot_ff;
   logic [W_W-1:0]       quot_in;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DIV_CNT_W-1:0] cnt_in;
   logic                 busy_ff;
   logic                 busy_in;
   logic                 done_ff;
   logic                 done_in;
   logic [NUM_W:0]       trial;
   logic                 qbit;

   // Since num <= den, num >> 1 is already below den; the remaining dividend
   // bits are num[0] and then FRAC_BITS zeros.
   always_comb begin
      trial   = {rem_ff, nb_ff};
      qbit    = (trial >= {1'b0, den});
      rem_in  = rem_ff;
      nb_in   = nb_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = num >> 1;
         nb_in   = num[0];
         cnt_in  = DIV_CNT_W'(DIV_STEPS - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = qbit ? NUM_W'(trial - {1'b0, den}) : trial[NUM_W-1:0];
         nb_in   = 1'b0;
         quot_in = {quot_ff[W_W-2:0], qbit};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      nb_ff   <= nb_in;
      quot_ff <= quot_in;
      cnt_ff  <= cnt_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

[hw/rtl/cbt_engine.sv]
`timescale 1ns / 1ps
// Evaluation engine: walks the points of the job at the queue head, forms
// the weights, accumulates the products and drives the result register.
// Depends on cbt_pkg and cbt_div.

module cbt_engine import cbt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    job_valid,
   input  job_type job,
   output logic    job_pop,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output out_type rsp_data
);

   eng_state_type state_ff;
   eng_state_type state_in;

   logic [CNT_W-1:0]        i_ff;
   logic [CNT_W-1:0]        i_in;
   logic [CNT_W-1:0]        u_ff;
   logic [CNT_W-1:0]        u_in;
   logic [SQ_W-1:0]         nn_ff;
   logic [SQ_W-1:0]         nn_in;
   logic [NUM_W-1:0]        n3_ff;
   logic [NUM_W-1:0]        n3_in;
   logic [SQ_W-1:0]         uu_ff;
   logic [SQ_W-1:0]         uu_in;
   logic [SQ_W-1:0]         ii_ff;
   logic [SQ_W-1:0]         ii_in;
   logic [2:0]              k_ff;
   logic [2:0]              k_in;
   logic                    prod_vld_ff;
   logic                    prod_vld_in;
   logic signed [PROD_W-1:0] prod_ff [3];
   logic signed [PROD_W-1:0] prod_in [3];
   logic signed [ACC_W-1:0]  acc_ff [3];
   logic signed [ACC_W-1:0]  acc_in [3];
   logic                    out_valid_ff;
   logic                    out_valid_in;
   out_type                 out_data_ff;
   out_type                 out_data_in;

   logic [NUM_W-1:0]        num [4];
   logic [NUM_W-1:0]        uui;
   logic [NUM_W-1:0]        uii;
   logic                    div_start;
   logic [3:0]              div_done;
   logic [W_W-1:0]          w [4];
   logic [W_W-1:0]          wsel;
   logic signed [COORD_W-1:0] csel [3];
   logic signed [COORD_W-1:0] sat [3];
   logic                    out_free;
   logic                    out_load;
   logic                    last;

   // Bernstein numerators from the registered powers
   always_comb begin
      uui    = NUM_W'(uu_ff) * NUM_W'(i_ff);
      uii    = NUM_W'(ii_ff) * NUM_W'(u_ff);
      num[0] = NUM_W'(uu_ff) * NUM_W'(u_ff);
      num[1] = uui + (uui << 1);
      num[2] = uii + (uii << 1);
      num[3] = NUM_W'(ii_ff) * NUM_W'(i_ff);
   end

   // One divider per weight, all started together
   for (genvar g = 0; g < 4; g++) begin : g_div
      cbt_div u_div (
         .clock (clock),
         .reset (reset),
         .start (div_start),
         .num   (num[g]),
         .den   (n3_ff),
         .done  (div_done[g]),
         .quot  (w[g])
      );
   end

   // Select the control point and weight for this multiply pass
   always_comb begin
      case (k_ff[1:0])
         2'd0: begin
            csel[0] = job.pts.p0_x; csel[1] = job.pts.p0_y; csel[2] = job.pts.p0_z;
         end
         2'd1: begin
            csel[0] = job.pts.c1_x; csel[1] = job.pts.c1_y; csel[2] = job.pts.c1_z;
         end
         2'd2: begin
            csel[0] = job.pts.c2_x; csel[1] = job.pts.c2_y; csel[2] = job.pts.c2_z;
         end
         default: begin
            csel[0] = job.pts.p3_x; csel[1] = job.pts.p3_y; csel[2] = job.pts.p3_z;
         end
      endcase
      wsel = w[k_ff[1:0]];
   end

   // Saturate the sums to the coordinate range
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         if (acc_ff[c] > ACC_W'(signed'({1'b0, {(COORD_W-1){1'b1}}}))) begin
            sat[c] = {1'b0, {(COORD_W-1){1'b1}}};
         end else if (acc_ff[c] < -(ACC_W'(signed'({1'b0, 1'b1, {(COORD_W-1){1'b0}}})))) begin
            sat[c] = {1'b1, {(COORD_W-1){1'b0}}};
         end else begin
            sat[c] = acc_ff[c][COORD_W-1:0];
         end
      end
   end

   assign out_free = !out_valid_ff || rsp_ready;
   assign last     = (i_ff == job.n);

   // Sequencer: next state and datapath controls
   always_comb begin
      state_in    = state_ff;
      i_in        = i_ff;
      u_in        = u_ff;
      nn_in       = nn_ff;
      n3_in       = n3_ff;
      uu_in       = uu_ff;
      ii_in       = ii_ff;
      k_in        = k_ff;
      prod_vld_in = 1'b0;
      div_start   = 1'b0;
      out_load    = 1'b0;
      job_pop     = 1'b0;
      for (int c = 0; c < 3; c++) begin
         prod_in[c] = prod_ff[c];
         acc_in[c]  = acc_ff[c];
      end
      case (state_ff)
         ENG_IDLE: begin
            if (job_valid) begin
               nn_in    = SQ_W'(job.n) * SQ_W'(job.n);
               i_in     = '0;
               state_in = ENG_CUBE;
            end
         end
         ENG_CUBE: begin
            n3_in    = NUM_W'(nn_ff) * NUM_W'(job.n);
            state_in = ENG_POW;
         end
         ENG_POW: begin
            u_in     = job.n - i_ff;
            uu_in    = SQ_W'(u_in) * SQ_W'(u_in);
            ii_in    = SQ_W'(i_ff) * SQ_W'(i_ff);
            state_in = ENG_NUM;
         end
         ENG_NUM: begin
            div_start = 1'b1;
            state_in  = ENG_DIV;
         end
         ENG_DIV: begin
            if (div_done[0]) begin
               k_in = '0;
               for (int c = 0; c < 3; c++) begin
                  acc_in[c] = '0;
               end
               state_in = ENG_MAC;
            end
         end
         ENG_MAC: begin
            // Issue one product per point, fold in the previous one
            if (k_ff != 3'd4) begin
               prod_vld_in = 1'b1;
               for (int c = 0; c < 3; c++) begin
                  prod_in[c] = csel[c] * signed'({1'b0, wsel});
               end
            end
            if (prod_vld_ff) begin
               for (int c = 0; c < 3; c++) begin
                  acc_in[c] = acc_ff[c] + ACC_W'(prod_ff[c] >>> FRAC_BITS);
               end
            end
            k_in = k_ff + 1'b1;
            if (k_ff == 3'd4) begin
               state_in = ENG_PUSH;
            end
         end
         ENG_PUSH: begin
            if (out_free) begin
               out_load = 1'b1;
               if (last) begin
                  job_pop  = 1'b1;
                  state_in = ENG_IDLE;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = ENG_POW;
               end
            end
         end
         default: state_in = ENG_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ENG_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Hold the result until taken
   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (out_load) begin
         out_valid_in           = 1'b1;
         out_data_in.curve_x    = sat[0];
         out_data_in.curve_y    = sat[1];
         out_data_in.curve_z    = sat[2];
         out_data_in.last_point = last;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         prod_vld_ff  <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         prod_vld_ff  <= prod_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      u_ff        <= u_in;
      nn_ff       <= nn_in;
      n3_ff       <= n3_in;
      uu_ff       <= uu_in;
      ii_ff       <= ii_in;
      k_ff        <= k_in;
      out_data_ff <= out_data_in;
      for (int c = 0; c < 3; c++) begin
         prod_ff[c] <= prod_in[c];
         acc_ff[c]  <= acc_in[c];
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // Dividers finish together and only while the sequencer waits on them
   a_div_sync: assert property (@(posedge clock) disable iff (reset)
      div_done[0] |-> (div_done == 4'b1111) && (state_ff == ENG_DIV))
      else $error("weight dividers out of step with sequencer");

   // Point index never runs past the segment count of a live job
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ENG_IDLE) |-> (job_valid && (i_ff <= job.n)))
      else $error("point index beyond segment count");

   // First point carries the start point at full weight
   a_start_weight: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ENG_MAC && i_ff == '0) |->
         (w[0] == W_W'(1 << FRAC_BITS) && w[3] == '0))
      else $error("start point weights wrong");

   // Retiring a job coincides with loading the flagged last point
   a_pop_last: assert property (@(posedge clock) disable iff (reset)
      job_pop |=> (rsp_valid && rsp_data.last_point))
      else $error("job retired without last point");

endmodule

[hw/rtl/cubic_bezier_tessellator_core.sv]
`timescale 1ns / 1ps
// Top level of the cubic Bezier tessellator: front end, job queue, engine.
// Depends on cbt_pkg, cbt_front, cbt_fifo, cbt_engine.
//
// Usage:
//   req_* takes one curve item (four 3-D control points, signed Q16.16).
//   rsp_* returns segment_count+1 curve points, the last one flagged by
//   last_point. Items are dropped without output when stroke_enabled is 0
//   or segment_count is below 2.
//   csr_we/csr_index/csr_wdata write segment_count (index 0) and
//   stroke_enabled (index 1); write only while the block is idle.
// Timing:
//   Each point is computed in turn: powers, the weight dividers (one
//   quotient bit per cycle), four multiply passes and the result load.
//   The two-entry job queue keeps accepting items while a curve runs.
// Reset: synchronous; registers return to segment_count 20, stroke on,
//   the queue empties and no result is pending.
// Stall: when rsp_ready is low the result register holds its point and
//   the engine waits with the next point computed; the queue fills and
//   then req_ready drops.

module cubic_bezier_tessellator_core import cbt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  in_type                req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output out_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   push_type q_wr;
   logic     q_full;
   logic     q_valid;
   job_type  q_head;
   logic     q_pop;

   cbt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_full    (q_full),
      .q_wr      (q_wr)
   );

   cbt_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .wr         (q_wr),
      .full       (q_full),
      .head_valid (q_valid),
      .head       (q_head),
      .pop        (q_pop)
   );

   cbt_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .job_valid (q_valid),
      .job       (q_head),
      .job_pop   (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
